// ===== rtl/core/obp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_pkg
// Shared widths, codes and tables of the orthophoto backprojection pipeline.
// ----------------------------------------------------------------------------
package obp_pkg;

    // grid point coordinates, signed Q.8 metres
    localparam int COORD_W  = 24;
    localparam int COEF_W   = 32;
    // pixel fields; the image is 4096 by 4096
    localparam int PIX_BITS = 12;

    // projection datapath
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FOLD_W   = SUM_W + 1;
    localparam int MAG_W    = SUM_W;
    localparam int QUOT_W   = MAG_W + PIX_BITS;

    // camera position, three signed Q.4 values
    localparam int CAM_W     = 21;
    localparam int CAM_SHIFT = 4;

    // view angle datapath
    localparam int DIFF_W       = 26;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int ROOT_W       = DIFF_W;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int PRESCALE     = 20;
    localparam int CORDIC_W     = 50;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int SCALE_W      = 61;
    localparam int DEG_SHIFT    = 30;
    localparam int DEG_REM_W    = SCALE_W - DEG_SHIFT;
    localparam int DEG_QUOT_W   = 15;
    localparam int ANGLE_W      = 15;
    localparam int DEG_RECIP_W     = 31;
    localparam int DEG_RECIP_SHIFT = 45;
    localparam int DEG_PROD_W      = DEG_REM_W + DEG_RECIP_W;

    // radians q30 to degrees q8: 180 * 256 * 10000 / 31415, rounded
    localparam logic [28:0]          DEG_NUM   = 29'd460800000;
    localparam logic [SCALE_W-1:0]   DEG_HALF  = 61'd31415 << (DEG_SHIFT - 1);
    // rounded-up reciprocal of 31415, exact for dividends below 2^30
    localparam logic [DEG_RECIP_W-1:0] DEG_RECIP =
        DEG_RECIP_W'((64'd1 << DEG_RECIP_SHIFT) / 64'd31415 + 64'd1);
    localparam logic [ANGLE_W-1:0]   ANGLE_MAX = 15'd23041;

    // pipeline depths of the two datapaths
    localparam int PROJ_LAT  = 5 + PIX_BITS;
    localparam int ANGLE_LAT = 4 + SQRT_STEPS + CORDIC_STEPS + 2;
    localparam int ALIGN_LAT = ANGLE_LAT - PROJ_LAT;

    typedef enum logic [1:0] {
        ST_SKIPPED  = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_OBSERVED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_ROW0_A    = 3'd0,
        REG_ROW0_B    = 3'd1,
        REG_ROW1_A    = 3'd2,
        REG_ROW1_B    = 3'd3,
        REG_ROW2_A    = 3'd4,
        REG_ROW2_B    = 3'd5,
        REG_CAMERA    = 3'd6,
        REG_SURFACE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][3:0][COEF_W-1:0] coef;
        logic [2:0][CAM_W-1:0]       cam;
    } obp_cfg_t;

    typedef struct packed {
        status_t               status;
        logic [PIX_BITS-1:0]   col;
        logic [PIX_BITS-1:0]   row;
    } proj_res_t;

    // arctangent of 2^-i in q30, truncated
    function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd7;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/obp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_in_if
// Grid point channel: coordinates, elevation and its valid flag.
// ----------------------------------------------------------------------------
interface obp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [obp_pkg::COORD_W-1:0]   world_east;
    logic signed [obp_pkg::COORD_W-1:0]   world_north;
    logic signed [obp_pkg::COORD_W-1:0]   height;
    logic                                 height_valid;

    modport source (
        output valid, world_east, world_north, height, height_valid,
        input  ready
    );

    modport sink (
        input  valid, world_east, world_north, height, height_valid,
        output ready
    );
endinterface

// ===== rtl/core/obp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_out_if
// Result channel: status, pixel position, view angle and elevated mark.
// ----------------------------------------------------------------------------
interface obp_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [obp_pkg::PIX_BITS-1:0]      pixel_col;
    logic [obp_pkg::PIX_BITS-1:0]      pixel_row;
    logic [obp_pkg::ANGLE_W-1:0]       view_angle;
    logic                              elevated_mark;

    modport source (
        output valid, status, pixel_col, pixel_row, view_angle, elevated_mark,
        input  ready
    );

    modport sink (
        input  valid, status, pixel_col, pixel_row, view_angle, elevated_mark,
        output ready
    );
endinterface

// ===== rtl/core/obp_proj.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_proj
// Camera matrix projection, depth sign fold, image bounds test and a
// radix-2 pipelined division to the pixel column and row.
// ----------------------------------------------------------------------------
module obp_proj (
    input  logic                                clk,
    input  logic                                en,
    input  obp_pkg::obp_cfg_t                   cfg,
    input  logic signed [obp_pkg::COORD_W-1:0]  east,
    input  logic signed [obp_pkg::COORD_W-1:0]  north,
    input  logic signed [obp_pkg::COORD_W-1:0]  up,
    input  logic                                up_valid,
    output obp_pkg::proj_res_t                  res
);

    typedef struct packed {
        obp_pkg::status_t                 status;
        logic [obp_pkg::MAG_W-1:0]        num_x;
        logic [obp_pkg::MAG_W-1:0]        num_y;
        logic [obp_pkg::MAG_W-1:0]        den;
        logic [obp_pkg::PIX_BITS-1:0]     q_x;
        logic [obp_pkg::PIX_BITS-1:0]     q_y;
    } div_t;

    logic signed [obp_pkg::COORD_W-1:0] coord [3];

    logic signed [obp_pkg::PROD_W-1:0] prod_reg [3][3];
    logic signed [obp_pkg::PROD_W-1:0] off_reg  [3];
    logic signed [obp_pkg::PAIR_W-1:0] pair_reg [3][2];
    logic signed [obp_pkg::SUM_W-1:0]  sum_reg  [3];
    logic signed [obp_pkg::FOLD_W-1:0] fold_reg [3];
    logic [3:0]                        hv_reg;
    div_t                              div_reg  [obp_pkg::PIX_BITS+1];

    logic                              outside;

    assign coord[0] = east;
    assign coord[1] = north;
    assign coord[2] = up;

    // products and the translation column
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(cfg.coef[r][c]) * coord[c];
                end
                off_reg[r] <= {{(obp_pkg::PROD_W-obp_pkg::COEF_W-8){cfg.coef[r][3][obp_pkg::COEF_W-1]}},
                               cfg.coef[r][3], 8'd0};
            end
            hv_reg <= {hv_reg[2:0], up_valid};
        end
    end

    // adder tree and sign fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pair_reg[r][0] <= obp_pkg::PAIR_W'(prod_reg[r][0])
                                + obp_pkg::PAIR_W'(prod_reg[r][1]);
                pair_reg[r][1] <= obp_pkg::PAIR_W'(prod_reg[r][2])
                                + obp_pkg::PAIR_W'(off_reg[r]);
                sum_reg[r]     <= obp_pkg::SUM_W'(pair_reg[r][0])
                                + obp_pkg::SUM_W'(pair_reg[r][1]);
                fold_reg[r]    <= sum_reg[2][obp_pkg::SUM_W-1]
                                ? -obp_pkg::FOLD_W'(sum_reg[r])
                                : obp_pkg::FOLD_W'(sum_reg[r]);
            end
        end
    end

    // strictly inside: z > 0, 0 < x < 4096 z, 0 < y < 4096 z
    always_comb
    begin
        outside = (fold_reg[2] == '0)
               || (fold_reg[0][obp_pkg::FOLD_W-1]) || (fold_reg[0] == '0)
               || (fold_reg[1][obp_pkg::FOLD_W-1]) || (fold_reg[1] == '0)
               || ({obp_pkg::PIX_BITS'(0), fold_reg[0][obp_pkg::MAG_W-1:0]}
                   >= {fold_reg[2][obp_pkg::MAG_W-1:0], obp_pkg::PIX_BITS'(0)})
               || ({obp_pkg::PIX_BITS'(0), fold_reg[1][obp_pkg::MAG_W-1:0]}
                   >= {fold_reg[2][obp_pkg::MAG_W-1:0], obp_pkg::PIX_BITS'(0)});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!hv_reg[3])
            begin
                div_reg[0].status <= obp_pkg::ST_SKIPPED;
            end
            else if (outside)
            begin
                div_reg[0].status <= obp_pkg::ST_OUTSIDE;
            end
            else
            begin
                div_reg[0].status <= obp_pkg::ST_OBSERVED;
            end
            div_reg[0].num_x <= fold_reg[0][obp_pkg::MAG_W-1:0];
            div_reg[0].num_y <= fold_reg[1][obp_pkg::MAG_W-1:0];
            div_reg[0].den   <= fold_reg[2][obp_pkg::MAG_W-1:0];
            div_reg[0].q_x   <= '0;
            div_reg[0].q_y   <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < obp_pkg::PIX_BITS; j++)
    begin : g_div
        logic [obp_pkg::QUOT_W-1:0] dshift;
        logic                       take_x;
        logic                       take_y;

        assign dshift = obp_pkg::QUOT_W'(div_reg[j].den) << (obp_pkg::PIX_BITS - 1 - j);
        assign take_x = obp_pkg::QUOT_W'(div_reg[j].num_x) >= dshift;
        assign take_y = obp_pkg::QUOT_W'(div_reg[j].num_y) >= dshift;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1].status <= div_reg[j].status;
                div_reg[j+1].den    <= div_reg[j].den;
                div_reg[j+1].num_x  <= take_x
                    ? obp_pkg::MAG_W'(obp_pkg::QUOT_W'(div_reg[j].num_x) - dshift)
                    : div_reg[j].num_x;
                div_reg[j+1].num_y  <= take_y
                    ? obp_pkg::MAG_W'(obp_pkg::QUOT_W'(div_reg[j].num_y) - dshift)
                    : div_reg[j].num_y;
                div_reg[j+1].q_x    <= div_reg[j].q_x
                    | (obp_pkg::PIX_BITS'(take_x) << (obp_pkg::PIX_BITS - 1 - j));
                div_reg[j+1].q_y    <= div_reg[j].q_y
                    | (obp_pkg::PIX_BITS'(take_y) << (obp_pkg::PIX_BITS - 1 - j));
            end
        end
    end

    assign res.status = div_reg[obp_pkg::PIX_BITS].status;
    assign res.col    = div_reg[obp_pkg::PIX_BITS].q_x;
    assign res.row    = div_reg[obp_pkg::PIX_BITS].q_y;

endmodule

// ===== rtl/core/obp_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_angle
// Elevation angle toward the camera: sight vector, pipelined integer square
// root, 30-stage vectoring CORDIC and conversion to degrees q8.
// ----------------------------------------------------------------------------
module obp_angle (
    input  logic                                        clk,
    input  logic                                        en,
    input  logic [2:0][obp_pkg::CAM_W-1:0]              cam,
    input  logic signed [obp_pkg::COORD_W-1:0]          east,
    input  logic signed [obp_pkg::COORD_W-1:0]          north,
    input  logic signed [obp_pkg::COORD_W-1:0]          up,
    output logic [obp_pkg::ANGLE_W-1:0]                 angle
);

    typedef struct packed {
        logic [obp_pkg::SQ_W-1:0]    rem;
        logic [obp_pkg::SQ_W-1:0]    root;
        logic [obp_pkg::DIFF_W-1:0]  y_abs;
    } sq_t;

    typedef struct packed {
        logic [obp_pkg::CORDIC_W-1:0] x;
        logic [obp_pkg::CORDIC_W-1:0] y;
        logic [obp_pkg::ANG_W-1:0]    ang;
    } cd_t;

    logic signed [obp_pkg::COORD_W-1:0] coord [3];
    logic [obp_pkg::DIFF_W-1:0]         diff  [3];

    logic signed [obp_pkg::DIFF_W-1:0]  de_reg;
    logic signed [obp_pkg::DIFF_W-1:0]  dn_reg;
    logic [obp_pkg::DIFF_W-1:0]         ya_reg;
    logic signed [obp_pkg::SQ_W-1:0]    sqe_next;
    logic signed [obp_pkg::SQ_W-1:0]    sqn_next;
    logic [obp_pkg::SQ_W-1:0]           sqe_reg;
    logic [obp_pkg::SQ_W-1:0]           sqn_reg;
    logic [obp_pkg::DIFF_W-1:0]         yb_reg;
    sq_t                                sq_reg [obp_pkg::SQRT_STEPS+1];
    cd_t                                cd_reg [obp_pkg::CORDIC_STEPS+1];

    logic [obp_pkg::ANG_W-2:0]          ang_pos;
    logic [obp_pkg::SCALE_W-1:0]        scale_next;
    logic [obp_pkg::DEG_REM_W-1:0]      deg_rem_reg;
    logic [obp_pkg::DEG_PROD_W-1:0]     deg_prod;
    logic [obp_pkg::DEG_QUOT_W-1:0]     deg_q_reg;

    assign coord[0] = east;
    assign coord[1] = north;
    assign coord[2] = up;

    // camera minus point, camera widened from q4 to q8
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = {{(obp_pkg::DIFF_W-obp_pkg::CAM_W-obp_pkg::CAM_SHIFT){cam[k][obp_pkg::CAM_W-1]}},
                       cam[k], obp_pkg::CAM_SHIFT'(0)}
                    - {{(obp_pkg::DIFF_W-obp_pkg::COORD_W){coord[k][obp_pkg::COORD_W-1]}},
                       coord[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            de_reg <= diff[0];
            dn_reg <= diff[1];
            ya_reg <= diff[2][obp_pkg::DIFF_W-1] ? -diff[2] : diff[2];
        end
    end

    assign sqe_next = obp_pkg::SQ_W'(de_reg) * obp_pkg::SQ_W'(de_reg);
    assign sqn_next = obp_pkg::SQ_W'(dn_reg) * obp_pkg::SQ_W'(dn_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqe_reg          <= sqe_next;
            sqn_reg          <= sqn_next;
            yb_reg           <= ya_reg;
            sq_reg[0].rem    <= sqe_reg + sqn_reg;
            sq_reg[0].root   <= '0;
            sq_reg[0].y_abs  <= yb_reg;
        end
    end

    // digit-by-digit square root, one result bit per stage
    for (genvar i = 0; i < obp_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        logic [obp_pkg::SQ_W-1:0] sbit;
        logic [obp_pkg::SQ_W-1:0] trial;
        logic                     take;

        assign sbit  = obp_pkg::SQ_W'(1) << (obp_pkg::SQ_W - 2 - 2 * i);
        assign trial = sq_reg[i].root + sbit;
        assign take  = sq_reg[i].rem >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[i+1].rem   <= take ? sq_reg[i].rem - trial : sq_reg[i].rem;
                sq_reg[i+1].root  <= take ? (sq_reg[i].root >> 1) + sbit
                                          : sq_reg[i].root >> 1;
                sq_reg[i+1].y_abs <= sq_reg[i].y_abs;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg[0].x   <= obp_pkg::CORDIC_W'({sq_reg[obp_pkg::SQRT_STEPS].root[obp_pkg::ROOT_W-1:0],
                                                 obp_pkg::PRESCALE'(0)});
            cd_reg[0].y   <= obp_pkg::CORDIC_W'({sq_reg[obp_pkg::SQRT_STEPS].y_abs,
                                                 obp_pkg::PRESCALE'(0)});
            cd_reg[0].ang <= '0;
        end
    end

    // vectoring rotations drive y toward zero and sum the angle
    for (genvar i = 0; i < obp_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [obp_pkg::CORDIC_W-1:0] xs;
        logic signed [obp_pkg::CORDIC_W-1:0] ys;
        logic                                rot;
        logic [obp_pkg::ANG_W-1:0]           step;

        assign xs   = $signed(cd_reg[i].x) >>> i;
        assign ys   = $signed(cd_reg[i].y) >>> i;
        assign rot  = $signed(cd_reg[i].y) > $signed(obp_pkg::CORDIC_W'(0));
        assign step = obp_pkg::atan_q30(5'(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_reg[i+1].x   <= rot ? cd_reg[i].x + ys   : cd_reg[i].x - ys;
                cd_reg[i+1].y   <= rot ? cd_reg[i].y - xs   : cd_reg[i].y + xs;
                cd_reg[i+1].ang <= rot ? cd_reg[i].ang + step : cd_reg[i].ang - step;
            end
        end
    end

    // negative angles clamp to zero, then scale with rounding
    assign ang_pos    = cd_reg[obp_pkg::CORDIC_STEPS].ang[obp_pkg::ANG_W-1]
                      ? '0 : cd_reg[obp_pkg::CORDIC_STEPS].ang[obp_pkg::ANG_W-2:0];
    assign scale_next = obp_pkg::SCALE_W'(ang_pos) * obp_pkg::SCALE_W'(obp_pkg::DEG_NUM)
                      + obp_pkg::DEG_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_rem_reg <= scale_next[obp_pkg::SCALE_W-1:obp_pkg::DEG_SHIFT];
        end
    end

    // divide by 31415 through its reciprocal; the dividend stays below 2^30
    assign deg_prod = obp_pkg::DEG_PROD_W'(deg_rem_reg)
                    * obp_pkg::DEG_PROD_W'(obp_pkg::DEG_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_q_reg <= deg_prod[obp_pkg::DEG_RECIP_SHIFT +: obp_pkg::DEG_QUOT_W];
        end
    end

    assign angle = (deg_q_reg > obp_pkg::ANGLE_MAX) ? obp_pkg::ANGLE_MAX : deg_q_reg;

endmodule

// ===== rtl/core/ortho_backprojection_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ortho_backprojection_point
// Projects surface grid points through a 3x4 camera matrix and reports
// pixel position and view elevation angle, one item per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage: grid points enter on the point channel (valid/ready), one result per
// item leaves on the result channel in the same order. The camera matrix,
// camera position and surface mode are written over the APB port, 64-bit
// registers at byte address 8*i, while no item is in flight.
// Depth: an item passes 63 register stages before its result can be taken;
// the depth is set by the view angle path (26-stage square root, 30-stage
// CORDIC and two stages that scale to degrees). The projection path
// finishes after 17 stages and is delayed to line up with it.
// Throughput: one item per cycle. All stages advance together; when the
// receiver holds ready low with a result waiting, the whole pipeline freezes
// and point.ready drops in the same cycle, so nothing is lost or repeated.
// Reset clears the config and valid registers, which empties the pipeline.
// ----------------------------------------------------------------------------
module ortho_backprojection_point (
    input  logic              clk,
    input  logic              rst_n,
    obp_in_if.sink            point,
    obp_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [63:0]                         proj_reg [6];
    logic [3*obp_pkg::CAM_W-1:0]         cam_reg;
    logic                                surf_reg;

    logic [obp_pkg::ANGLE_LAT:0]         vld_reg;
    obp_pkg::proj_res_t                  dl_reg [obp_pkg::ALIGN_LAT];

    logic [1:0]                          status_reg;
    logic [obp_pkg::PIX_BITS-1:0]        col_reg;
    logic [obp_pkg::PIX_BITS-1:0]        row_reg;
    logic [obp_pkg::ANGLE_W-1:0]         angle_reg;
    logic                                mark_reg;

    logic                                en;
    logic                                wr;
    obp_pkg::reg_idx_t                   idx;
    obp_pkg::obp_cfg_t                   cfg;
    obp_pkg::proj_res_t                  proj_res;
    obp_pkg::proj_res_t                  aligned;
    logic [obp_pkg::ANGLE_W-1:0]         angle;
    logic                                observed;

    // configuration registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = obp_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                proj_reg[k] <= '0;
            end
            cam_reg  <= '0;
            surf_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                obp_pkg::REG_ROW0_A:  proj_reg[0] <= pwdata;
                obp_pkg::REG_ROW0_B:  proj_reg[1] <= pwdata;
                obp_pkg::REG_ROW1_A:  proj_reg[2] <= pwdata;
                obp_pkg::REG_ROW1_B:  proj_reg[3] <= pwdata;
                obp_pkg::REG_ROW2_A:  proj_reg[4] <= pwdata;
                obp_pkg::REG_ROW2_B:  proj_reg[5] <= pwdata;
                obp_pkg::REG_CAMERA:  cam_reg     <= pwdata[3*obp_pkg::CAM_W-1:0];
                obp_pkg::REG_SURFACE: surf_reg    <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            obp_pkg::REG_ROW0_A:  prdata = proj_reg[0];
            obp_pkg::REG_ROW0_B:  prdata = proj_reg[1];
            obp_pkg::REG_ROW1_A:  prdata = proj_reg[2];
            obp_pkg::REG_ROW1_B:  prdata = proj_reg[3];
            obp_pkg::REG_ROW2_A:  prdata = proj_reg[4];
            obp_pkg::REG_ROW2_B:  prdata = proj_reg[5];
            obp_pkg::REG_CAMERA:  prdata = 64'(cam_reg);
            obp_pkg::REG_SURFACE: prdata = 64'(surf_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            cfg.coef[r][0] = proj_reg[2*r][31:0];
            cfg.coef[r][1] = proj_reg[2*r][63:32];
            cfg.coef[r][2] = proj_reg[2*r+1][31:0];
            cfg.coef[r][3] = proj_reg[2*r+1][63:32];
            cfg.cam[r]     = cam_reg[r*obp_pkg::CAM_W +: obp_pkg::CAM_W];
        end
    end

    // pipeline advances unless a finished result is held up
    assign en          = !vld_reg[obp_pkg::ANGLE_LAT] || result.ready;
    assign point.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[obp_pkg::ANGLE_LAT-1:0], point.valid};
        end
    end

    obp_proj u_proj (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg),
        .east     (point.world_east),
        .north    (point.world_north),
        .up       (point.height),
        .up_valid (point.height_valid),
        .res      (proj_res)
    );

    obp_angle u_angle (
        .clk   (clk),
        .en    (en),
        .cam   (cfg.cam),
        .east  (point.world_east),
        .north (point.world_north),
        .up    (point.height),
        .angle (angle)
    );

    // line the projection result up with the angle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= proj_res;
            for (int k = 1; k < obp_pkg::ALIGN_LAT; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    assign aligned  = dl_reg[obp_pkg::ALIGN_LAT-1];
    assign observed = aligned.status == obp_pkg::ST_OBSERVED;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= aligned.status;
            col_reg    <= observed ? aligned.col : '0;
            row_reg    <= observed ? aligned.row : '0;
            angle_reg  <= observed ? angle : '0;
            mark_reg   <= observed && surf_reg;
        end
    end

    assign result.valid         = vld_reg[obp_pkg::ANGLE_LAT];
    assign result.status        = status_reg;
    assign result.pixel_col     = col_reg;
    assign result.pixel_row     = row_reg;
    assign result.view_angle    = angle_reg;
    assign result.elevated_mark = mark_reg;

endmodule
